@@ sv/olist_pkg.sv @@
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and codes for the ordered list engine: request and response
// structs, opcodes, status codes, cell commands and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int WORD_W           = 32;

    // opcodes
    localparam logic [3:0] OP_ADD_FIRST  = 4'd0;
    localparam logic [3:0] OP_ADD_LAST   = 4'd1;
    localparam logic [3:0] OP_ADD_AT     = 4'd2;
    localparam logic [3:0] OP_GET        = 4'd3;
    localparam logic [3:0] OP_UPDATE     = 4'd4;
    localparam logic [3:0] OP_REM_FIRST  = 4'd5;
    localparam logic [3:0] OP_REM_LAST   = 4'd6;
    localparam logic [3:0] OP_REM_AT     = 4'd7;
    localparam logic [3:0] OP_REM_VALUE  = 4'd8;
    localparam logic [3:0] OP_FIND_FIRST = 4'd9;
    localparam logic [3:0] OP_FIND_LAST  = 4'd10;
    localparam logic [3:0] OP_QUERY      = 4'd11;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_INDEX = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]               opcode;
        logic signed [WORD_W-1:0] value;
        logic [4:0]               position;
    } olist_req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic                     found;
        logic signed [WORD_W-1:0] read_value;
        logic [3:0]               found_index;
        logic [4:0]               count;
        logic signed [WORD_W-1:0] first_value;
        logic signed [WORD_W-1:0] last_value;
    } olist_rsp_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_DELETE,
        CM_WRITE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t        mode;
        logic [WORD_W-1:0] value;
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } olist_state_t;

endpackage

`default_nettype wire

@@ sv/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed words with insert, remove, read, write and
// search requests, built as a row of shifting slot cells.
// ----------------------------------------------------------------------------
// A request transfers on a rising edge with start high and busy low. Each
// request has a transfer cycle and an execute cycle: in the transfer cycle
// every cell compares its word with the request value and registers a match
// flag; in the next cycle (busy high) the controller checks the request,
// encodes the match flags and broadcasts one command that every cell applies
// at once (shift up, shift down, or write one slot). The response is on rsp
// for exactly one cycle with done high, in the cycle after the execute cycle;
// the receiver cannot stall it, so capture it on that edge. A new request may
// transfer in the same cycle the response is shown, but not while busy.
// count, first_value and last_value reflect the list after the request. A
// failed request leaves the list untouched. found_index and count carry the
// low bits of the position and count.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine #(
    parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire olist_pkg::olist_req_t req,
    output logic                       done,
    output olist_pkg::olist_rsp_t      rsp
);
    import olist_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    olist_state_t state_reg;
    olist_state_t state_next;

    olist_req_t req_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              found_reg;
    logic              found_next;
    logic [WORD_W-1:0] rd_reg;
    logic [WORD_W-1:0] rd_next;
    logic [3:0]        fidx_reg;
    logic [3:0]        fidx_next;
    logic              done_reg;
    logic              done_next;

    logic              accept;
    cell_cmd_t         cmd;
    logic [IW-1:0]     cmd_at;

    logic [WORD_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0] match;
    logic              any_match;
    logic [IW-1:0]     first_idx;
    logic [IW-1:0]     last_idx;

    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     cnt_ext;
    logic [PW-1:0]     ins_pos;
    logic [WORD_W-1:0] pos_word;
    logic [WORD_W-1:0] last_word;

    assign accept = start && !busy;
    assign busy   = (state_reg == ST_EXEC);

    // ---- row of cells --------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        olist_cell #(
            .INDEX    (g),
            .CAPACITY (CAPACITY),
            .IW       (IW),
            .CW       (CW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .at         (cmd_at),
            .left_data  (left_w),
            .right_data (right_w),
            .cmp_en     (accept),
            .cmp_value  (req.value),
            .count      (count_reg),
            .data       (cell_data[g]),
            .match      (match[g])
        );
    end

    olist_prio #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_prio (
        .match     (match),
        .any       (any_match),
        .first_idx (first_idx),
        .last_idx  (last_idx)
    );

    // ---- read taps: slot at request position and back slot ---------------
    always_comb
    begin
        pos_word  = '0;
        last_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (PW'(i) == pos_ext)
                pos_word = pos_word | cell_data[i];
            if (PW'(i) + 1'b1 == cnt_ext)
                last_word = last_word | cell_data[i];
        end
    end

    assign pos_ext = PW'(req_reg.position);
    assign cnt_ext = PW'(count_reg);

    // ---- controller -----------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        found_next  = found_reg;
        rd_next     = rd_reg;
        fidx_next   = fidx_reg;
        done_next   = 1'b0;
        cmd.mode    = CM_HOLD;
        cmd.value   = req_reg.value;
        cmd_at      = '0;
        ins_pos     = pos_ext;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                status_next = STAT_OK;
                found_next  = 1'b0;
                rd_next     = '0;
                fidx_next   = '0;

                unique case (req_reg.opcode)
                    OP_ADD_FIRST, OP_ADD_LAST, OP_ADD_AT:
                    begin
                        if (req_reg.opcode == OP_ADD_FIRST)
                            ins_pos = '0;
                        else if (req_reg.opcode == OP_ADD_LAST)
                            ins_pos = cnt_ext;
                        if (ins_pos > cnt_ext)
                            status_next = STAT_INDEX;
                        else if (cnt_ext >= PW'(CAPACITY))
                            status_next = STAT_FULL;
                        else
                        begin
                            cmd.mode   = CM_INSERT;
                            cmd_at     = IW'(ins_pos);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    OP_GET:
                    begin
                        if (pos_ext >= cnt_ext)
                            status_next = STAT_INDEX;
                        else
                            rd_next = pos_word;
                    end
                    OP_UPDATE:
                    begin
                        if (pos_ext >= cnt_ext)
                            status_next = STAT_INDEX;
                        else
                        begin
                            cmd.mode = CM_WRITE;
                            cmd_at   = IW'(pos_ext);
                        end
                    end
                    OP_REM_FIRST, OP_REM_LAST:
                    begin
                        if (count_reg == '0)
                            status_next = STAT_EMPTY;
                        else
                        begin
                            cmd.mode   = CM_DELETE;
                            cmd_at     = (req_reg.opcode == OP_REM_FIRST) ?
                                         '0 : IW'(count_reg - 1'b1);
                            count_next = count_reg - 1'b1;
                        end
                    end
                    OP_REM_AT:
                    begin
                        if (pos_ext >= cnt_ext)
                            status_next = STAT_INDEX;
                        else
                        begin
                            cmd.mode   = CM_DELETE;
                            cmd_at     = IW'(pos_ext);
                            count_next = count_reg - 1'b1;
                        end
                    end
                    OP_REM_VALUE, OP_FIND_FIRST, OP_FIND_LAST:
                    begin
                        if (count_reg == '0)
                            status_next = STAT_EMPTY;
                        else if (any_match)
                        begin
                            found_next = 1'b1;
                            if (req_reg.opcode == OP_FIND_LAST)
                                fidx_next = 4'(32'(last_idx));
                            else
                                fidx_next = 4'(32'(first_idx));
                            // drop the first match and close the gap
                            if (req_reg.opcode == OP_REM_VALUE)
                            begin
                                cmd.mode   = CM_DELETE;
                                cmd_at     = first_idx;
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        // query and unused codes: report only
                        status_next = STAT_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req;
        status_reg <= status_next;
        found_reg  <= found_next;
        rd_reg     <= rd_next;
        fidx_reg   <= fidx_next;
    end

    // ---- response --------------------------------------------------------
    // count, first and last come straight from the list, which holds still
    // until the next execute cycle.
    assign done             = done_reg;
    assign rsp.status       = status_reg;
    assign rsp.found        = found_reg;
    assign rsp.read_value   = rd_reg;
    assign rsp.found_index  = fidx_reg;
    assign rsp.count        = 5'(count_reg);
    assign rsp.first_value  = (count_reg != '0) ? cell_data[0] : '0;
    assign rsp.last_value   = (count_reg != '0) ? last_word : '0;

endmodule

`default_nettype wire

@@ sv/olist_cell.sv @@
// ----------------------------------------------------------------------------
// olist_cell
// One list slot: holds a word, shifts toward either neighbor on insert or
// delete, takes a broadcast word on write, and registers a match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_cell #(
    parameter int INDEX    = 0,
    parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY,
    parameter int IW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                             clk,
    input  wire olist_pkg::cell_cmd_t             cmd,
    input  wire logic [IW-1:0]                    at,
    input  wire logic [olist_pkg::WORD_W-1:0]     left_data,
    input  wire logic [olist_pkg::WORD_W-1:0]     right_data,
    input  wire logic                             cmp_en,
    input  wire logic [olist_pkg::WORD_W-1:0]     cmp_value,
    input  wire logic [CW-1:0]                    count,
    output logic      [olist_pkg::WORD_W-1:0]     data,
    output logic                                  match
);
    import olist_pkg::*;

    localparam logic [IW-1:0] MY_IDX  = IW'(INDEX);
    localparam logic [CW-1:0] MY_CIDX = CW'(INDEX);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              match_reg;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.mode)
            CM_HOLD:   data_next = data_reg;
            CM_INSERT:
            begin
                if (MY_IDX > at)
                    data_next = left_data;
                else if (MY_IDX == at)
                    data_next = cmd.value;
            end
            CM_DELETE:
            begin
                if (MY_IDX >= at)
                    data_next = right_data;
            end
            CM_WRITE:
            begin
                if (MY_IDX == at)
                    data_next = cmd.value;
            end
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (cmp_en)
            match_reg <= (MY_CIDX < count) && (data_reg == cmp_value);
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

@@ sv/olist_prio.sv @@
// ----------------------------------------------------------------------------
// olist_prio
// Match encoder: turns the row of cell match flags into the lowest and the
// highest matching position.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_prio #(
    parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY,
    parameter int IW       = $clog2(CAPACITY)
) (
    input  wire logic [CAPACITY-1:0] match,
    output logic                     any,
    output logic [IW-1:0]            first_idx,
    output logic [IW-1:0]            last_idx
);
    import olist_pkg::*;

    logic [CAPACITY-1:0] low_hot;
    logic [CAPACITY-1:0] rev;
    logic [CAPACITY-1:0] rev_hot;
    logic [IW-1:0]       rev_idx;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            rev[i] = match[CAPACITY-1-i];
        // isolate the lowest set bit of each vector
        low_hot = match & (~match + 1'b1);
        rev_hot = rev & (~rev + 1'b1);
        first_idx = '0;
        rev_idx   = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (low_hot[i])
                first_idx = first_idx | IW'(i);
            if (rev_hot[i])
                rev_idx = rev_idx | IW'(i);
        end
        last_idx = IW'(CAPACITY - 1) - rev_idx;
        any      = |match;
    end

endmodule

`default_nettype wire
